@@ rtl/lru_set_assoc_cache_sim_macros.svh @@
// shared assertion macros
`ifndef LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_SIM_MACROS_SVH

// property that must hold on the same edge
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that must hold on the following edge
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lru_cache_pkg.sv @@
package lru_cache_pkg;

	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 4;
	localparam int ADDR_WIDTH_DEF   = 64;

	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_WAYS       = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

	localparam logic [2:0] SET_BITS_RST   = 3'd4;
	localparam logic [2:0] WAYS_RST       = 3'd1;
	localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

endpackage

@@ rtl/lru_set_assoc_cache_sim.sv @@
// channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------------
// request  | in_valid / in_stall         | req_type, address
// result   | out_valid / out_stall       | first_hit, evicted, second_hit, *_total
// config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// each access first reads the set row, then updates it and writes it back
// one access in flight at a time; in_stall stays high until its result is registered
// a full, stalled result register holds the update back and keeps in_stall high
// reset takes effect at once: per-row flags mark every set as empty, no clearing pass
module lru_set_assoc_cache_sim #(
	parameter int MAX_SET_BITS = lru_cache_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = lru_cache_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH   = lru_cache_pkg::ADDR_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        first_hit,
	output logic        evicted,
	output logic        second_hit,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [31:0] eviction_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int SI_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][RW-1:0]         rank;
	} row_t;

	logic [2:0] set_bits_q;
	logic [2:0] ways_q;
	logic [4:0] block_bits_q;

	logic [31:0] hit_q;
	logic [31:0] miss_q;
	logic [31:0] evict_q;

	logic out_valid_q;
	logic first_hit_q;
	logic evicted_q;
	logic second_hit_q;

	logic                  busy_s1;
	logic [1:0]            req_s1;
	logic [SI_W-1:0]       set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic                  init_s1;
	row_t                  rd_row_s1;

	row_t            mem [SETS];
	logic [SETS-1:0] row_init_q;

	logic                  accept;
	logic                  commit;
	logic [ADDR_WIDTH-1:0] addr_a;
	logic [2:0]            sb;
	logic [5:0]            tag_shift;
	logic [ADDR_WIDTH-1:0] shifted;
	logic [SI_W-1:0]       set_mask;
	logic [SI_W-1:0]       set_idx;
	logic [ADDR_WIDTH-1:0] tag_in;

	logic                    acc;
	logic                    mod;
	logic [2:0]              ways_c;
	logic [MAX_WAYS-1:0]     use_w;
	logic [MAX_WAYS-1:0]     v_eff;
	logic [MAX_WAYS-1:0][RW-1:0] r_eff;
	logic [MAX_WAYS-1:0]     hit_vec;
	logic [MAX_WAYS-1:0]     inv_vec;
	logic                    hit;
	logic                    any_inv;
	logic [RW-1:0]           hit_way;
	logic [RW-1:0]           inv_way;
	logic [RW-1:0]           lru_way;
	logic [RW-1:0]           k;
	logic                    k_valid;
	logic [RW-1:0]           old_rank;
	row_t                    new_row;
	logic                    do_evict;
	logic [1:0]              hit_inc;
	logic                    miss_inc;
	logic [31:0]             hit_next;
	logic [31:0]             miss_next;
	logic [31:0]             evict_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_s1;
	assign accept    = in_valid & ~busy_s1;
	assign commit    = busy_s1 & (~out_valid_q | ~out_stall);

	// address split
	assign addr_a    = address[ADDR_WIDTH-1:0];
	assign sb        = (set_bits_q > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
	assign tag_shift = {1'b0, block_bits_q} + {3'b000, sb};
	assign shifted   = addr_a >> block_bits_q;
	assign set_mask  = ~({SI_W{1'b1}} << sb);
	assign set_idx   = shifted[SI_W-1:0] & set_mask;
	assign tag_in    = addr_a >> tag_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= lru_cache_pkg::SET_BITS_RST;
			ways_q       <= lru_cache_pkg::WAYS_RST;
			block_bits_q <= lru_cache_pkg::BLOCK_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lru_cache_pkg::REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				lru_cache_pkg::REG_WAYS:       ways_q       <= cfg_data[2:0];
				lru_cache_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// set row memory
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= mem[set_idx];
		end
		if (commit && acc) begin
			mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			set_s1  <= set_idx;
			tag_s1  <= tag_in;
			init_s1 <= row_init_q[set_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1    <= 1'b0;
			row_init_q <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (commit) begin
				busy_s1 <= 1'b0;
			end
			if (commit && acc) begin
				row_init_q[set_s1] <= 1'b1;
			end
		end
	end

	// lookup and replacement
	assign acc    = (req_s1 == lru_cache_pkg::REQ_LOAD) || (req_s1 == lru_cache_pkg::REQ_STORE)
		|| (req_s1 == lru_cache_pkg::REQ_MODIFY);
	assign mod    = (req_s1 == lru_cache_pkg::REQ_MODIFY);
	assign ways_c = (ways_q == 3'd0) ? 3'd1 : ways_q;
	assign v_eff  = init_s1 ? rd_row_s1.valid : '0;
	assign r_eff  = init_s1 ? rd_row_s1.rank : '0;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			use_w[i]   = (i < int'(ways_c));
			hit_vec[i] = use_w[i] & v_eff[i] & (rd_row_s1.tag[i] == tag_s1);
			inv_vec[i] = use_w[i] & ~v_eff[i];
		end
	end

	assign hit     = |hit_vec;
	assign any_inv = |inv_vec;

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = RW'(i);
			end
			if (inv_vec[i]) begin
				inv_way = RW'(i);
			end
		end
	end

	always_comb begin
		lru_way = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (use_w[i] && (r_eff[i] > r_eff[lru_way])) begin
				lru_way = RW'(i);
			end
		end
	end

	assign k        = hit ? hit_way : (any_inv ? inv_way : lru_way);
	assign k_valid  = v_eff[k];
	assign old_rank = r_eff[k];
	assign do_evict = acc & ~hit & ~any_inv;

	always_comb begin
		new_row.tag   = rd_row_s1.tag;
		new_row.valid = v_eff;
		new_row.rank  = r_eff;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if ((RW'(i) != k) && use_w[i] && v_eff[i] && (!k_valid || (r_eff[i] < old_rank))
				&& (r_eff[i] < RANK_MAX)) begin
				new_row.rank[i] = r_eff[i] + RW'(1);
			end
		end
		new_row.rank[k]  = '0;
		new_row.valid[k] = 1'b1;
		if (!hit) begin
			new_row.tag[k] = tag_s1;
		end
	end

	// saturating totals
	assign hit_inc    = {1'b0, acc & hit} + {1'b0, mod};
	assign miss_inc   = acc & ~hit;
	assign hit_next   = (hit_q > (lru_cache_pkg::CNT_MAX - 32'(hit_inc)))
		? lru_cache_pkg::CNT_MAX : hit_q + 32'(hit_inc);
	assign miss_next  = (miss_inc && (miss_q != lru_cache_pkg::CNT_MAX)) ? miss_q + 32'd1 : miss_q;
	assign evict_next = (do_evict && (evict_q != lru_cache_pkg::CNT_MAX))
		? evict_q + 32'd1 : evict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (commit) begin
			hit_q       <= hit_next;
			miss_q      <= miss_next;
			evict_q     <= evict_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			first_hit_q  <= acc & hit;
			evicted_q    <= do_evict;
			second_hit_q <= mod;
		end
	end

	assign out_valid      = out_valid_q;
	assign first_hit      = first_hit_q;
	assign evicted        = evicted_q;
	assign second_hit     = second_hit_q;
	assign hit_total      = hit_q;
	assign miss_total     = miss_q;
	assign eviction_total = evict_q;

endmodule

@@ rtl/lru_cache_chk.sv @@
`include "lru_set_assoc_cache_sim_macros.svh"

module lru_cache_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        first_hit,
	input logic        evicted,
	input logic [31:0] hit_total,
	input logic [31:0] miss_total
);

	`LRU_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction taken while busy")
	`LRU_ASSERT_NOW(a_evict_is_miss, out_valid && evicted, !first_hit, "eviction reported on a hit")
	`LRU_ASSERT_NEXT(a_hits_monotone, 1'b1, hit_total >= $past(hit_total), "hit total went down")
	`LRU_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(miss_total), "stalled result changed")

endmodule

bind lru_set_assoc_cache_sim lru_cache_chk u_chk (.*);
